>>> design/rbts_pkg.sv
`default_nettype none
package rbts_pkg;

	typedef enum logic [1:0] {
		OP_RESTART = 2'd0,
		OP_ASK     = 2'd1,
		OP_REPORT  = 2'd2,
		OP_POST    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ACT_ACK       = 2'd0,
		ACT_SLEEP     = 2'd1,
		ACT_SEND      = 2'd2,
		ACT_TELEMETRY = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		CFG_COOLDOWN_BASE   = 3'd0,
		CFG_COOLDOWN_MAX    = 3'd1,
		CFG_TELEMETRY_LONG  = 3'd2,
		CFG_TELEMETRY_SHORT = 3'd3,
		CFG_RECONNECT_AFTER = 3'd4,
		CFG_GIVE_UP         = 3'd5
	} cfg_index_t;

	localparam int CfgIndexW = 3;
	localparam int CfgDataW  = 32;

	localparam logic [15:0] RstCooldownBase   = 16'd100;
	localparam logic [15:0] RstCooldownMax    = 16'd60000;
	localparam logic [15:0] RstTelemetryLong  = 16'd4000;
	localparam logic [15:0] RstTelemetryShort = 16'd1000;
	localparam logic [31:0] RstReconnectAfter = 32'd10000;
	localparam logic [3:0]  RstGiveUp         = 4'd5;

	typedef struct packed {
		action_t     action;
		logic [15:0] sleep_ms;
		logic [15:0] sent_tag;
		logic        sent_is_info;
	} result_t;

endpackage
`default_nettype wire

>>> design/rbts_ifs.sv
`default_nettype none
interface rbts_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [31:0] now_ms;
	logic [1:0]  outcome;
	logic        printing;
	logic        background_busy;
	logic        info_changed;
	logic        offered_valid;
	logic        event_is_info;
	logic [15:0] event_tag;

	modport source (
		output valid, operation, now_ms, outcome, printing, background_busy,
		output info_changed, offered_valid, event_is_info, event_tag,
		input  ready
	);
	modport sink (
		input  valid, operation, now_ms, outcome, printing, background_busy,
		input  info_changed, offered_valid, event_is_info, event_tag,
		output ready
	);
endinterface

interface rbts_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [15:0] sleep_ms;
	logic [15:0] sent_tag;
	logic        sent_is_info;

	modport source (
		output valid, action, sleep_ms, sent_tag, sent_is_info,
		input  ready
	);
	modport sink (
		input  valid, action, sleep_ms, sent_tag, sent_is_info,
		output ready
	);
endinterface
`default_nettype wire

>>> design/retry_backoff_telemetry_scheduler.sv
// Retry back-off and telemetry scheduler. Every request beat (restart, ask, report, post) is
// handled combinationally and yields exactly one response beat, registered in the output or, if
// that is held, the skid register; a new request may be accepted every cycle while req.ready is
// high. req.ready only drops when both output and skid register hold responses that the sink has
// not taken yet. Configuration registers are written through cfg_we/cfg_index/cfg_data while no
// request is in flight; the user must keep to this, the block itself does not enforce it.
`default_nettype none
module retry_backoff_telemetry_scheduler
	import rbts_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	rbts_req_if.sink                  req,
	rbts_rsp_if.source                rsp,
	input  wire logic                 cfg_we,
	input  wire logic [CfgIndexW-1:0] cfg_index,
	input  wire logic [CfgDataW-1:0]  cfg_data
);

	logic [15:0] cooldown_base_q, cooldown_max_q, telemetry_long_q, telemetry_short_q;
	logic [31:0] reconnect_after_q;
	logic [3:0]  give_up_q;

	logic        cooldown_pending_q, cooldown_pending_d;
	logic        cooldown_valid_q, cooldown_valid_d;
	logic [15:0] cooldown_ms_q, cooldown_ms_d;
	logic [3:0]  failed_count_q, failed_count_d;
	logic        telemetry_valid_q, telemetry_valid_d;
	logic [31:0] telemetry_stamp_q, telemetry_stamp_d;
	logic        success_valid_q, success_valid_d;
	logic [31:0] success_stamp_q, success_stamp_d;
	logic        pending_valid_q, pending_valid_d;
	logic        pending_is_info_q, pending_is_info_d;
	logic [15:0] pending_tag_q, pending_tag_d;
	logic        info_dirty_q, info_dirty_d;

	result_t     res;
	result_t     out_q, skid_q;
	logic        out_valid_q, skid_valid_q;
	logic        accept, out_free;

	assign accept    = req.valid && req.ready;
	assign req.ready = !skid_valid_q;
	assign out_free  = !out_valid_q || rsp.ready;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cooldown_base_q   <= RstCooldownBase;
			cooldown_max_q    <= RstCooldownMax;
			telemetry_long_q  <= RstTelemetryLong;
			telemetry_short_q <= RstTelemetryShort;
			reconnect_after_q <= RstReconnectAfter;
			give_up_q         <= RstGiveUp;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_COOLDOWN_BASE:   cooldown_base_q   <= cfg_data[15:0];
				CFG_COOLDOWN_MAX:    cooldown_max_q    <= cfg_data[15:0];
				CFG_TELEMETRY_LONG:  telemetry_long_q  <= cfg_data[15:0];
				CFG_TELEMETRY_SHORT: telemetry_short_q <= cfg_data[15:0];
				CFG_RECONNECT_AFTER: reconnect_after_q <= cfg_data;
				CFG_GIVE_UP:         give_up_q         <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		logic [31:0] tel_since;
		logic [15:0] tel_ivl;
		logic [31:0] ok_since;
		logic [4:0]  fail_sum;
		logic        give_up_hit;
		logic        pend_after;
		logic [15:0] cd_prev;
		logic [16:0] cd_dbl;
		logic        info_n;
		logic        ask_valid, ask_info;
		logic [15:0] ask_tag;

		cooldown_pending_d = cooldown_pending_q;
		cooldown_valid_d   = cooldown_valid_q;
		cooldown_ms_d      = cooldown_ms_q;
		failed_count_d     = failed_count_q;
		telemetry_valid_d  = telemetry_valid_q;
		telemetry_stamp_d  = telemetry_stamp_q;
		success_valid_d    = success_valid_q;
		success_stamp_d    = success_stamp_q;
		pending_valid_d    = pending_valid_q;
		pending_is_info_d  = pending_is_info_q;
		pending_tag_d      = pending_tag_q;
		info_dirty_d       = info_dirty_q;

		res              = '0;
		res.action       = ACT_ACK;

		tel_since   = req.now_ms - telemetry_stamp_q;
		tel_ivl     = (req.printing || req.background_busy) ? telemetry_short_q
		                                                    : telemetry_long_q;
		ok_since    = success_valid_q ? (req.now_ms - success_stamp_q) : 32'd0;
		fail_sum    = {1'b0, failed_count_q} + 5'd1;
		give_up_hit = fail_sum >= {1'b0, give_up_q};
		pend_after  = pending_valid_q && !(give_up_hit && !pending_is_info_q);
		cd_prev     = cooldown_valid_q ? cooldown_ms_q : {1'b0, cooldown_base_q[15:1]};
		cd_dbl      = {cd_prev, 1'b0};

		info_n    = info_dirty_q || (!pending_valid_q && req.info_changed);
		ask_valid = pending_valid_q;
		ask_info  = pending_is_info_q;
		ask_tag   = pending_tag_q;
		if (!pending_valid_q) begin
			if (info_n) begin
				ask_valid = 1'b1;
				ask_info  = 1'b1;
				ask_tag   = '0;
			end else if (req.offered_valid) begin
				ask_valid = 1'b1;
				ask_info  = req.event_is_info;
				ask_tag   = req.event_tag;
			end
		end

		unique case (op_t'(req.operation))
			OP_RESTART: begin
				info_dirty_d       = 1'b1;
				telemetry_valid_d  = 1'b0;
				telemetry_stamp_d  = '0;
				cooldown_valid_d   = 1'b0;
				cooldown_ms_d      = '0;
				cooldown_pending_d = 1'b0;
				failed_count_d     = '0;
			end
			OP_ASK: begin
				if (cooldown_pending_q) begin
					cooldown_pending_d = 1'b0;
					res.action         = ACT_SLEEP;
					res.sleep_ms       = cooldown_ms_q;
				end else begin
					info_dirty_d      = info_n;
					pending_valid_d   = ask_valid;
					pending_is_info_d = ask_info;
					pending_tag_d     = ask_tag;
					if (ask_valid) begin
						res.action       = ACT_SEND;
						res.sent_tag     = ask_tag;
						res.sent_is_info = ask_info;
					end else if (telemetry_valid_q && (tel_since < {16'd0, tel_ivl})) begin
						res.action   = ACT_SLEEP;
						res.sleep_ms = tel_ivl - tel_since[15:0];
					end else begin
						res.action = ACT_TELEMETRY;
					end
				end
			end
			OP_REPORT: begin
				if (!req.outcome[1]) begin
					// ok or refused
					success_valid_d    = 1'b1;
					success_stamp_d    = req.now_ms;
					cooldown_pending_d = 1'b0;
					cooldown_valid_d   = 1'b0;
					cooldown_ms_d      = '0;
					failed_count_d     = '0;
					if (pending_valid_q) begin
						if (pending_is_info_q) begin
							info_dirty_d = 1'b0;
						end
						pending_valid_d   = 1'b0;
						telemetry_valid_d = 1'b0;
					end else begin
						telemetry_valid_d = 1'b1;
						telemetry_stamp_d = req.now_ms;
					end
				end else begin
					failed_count_d  = give_up_hit ? 4'd0 : fail_sum[3:0];
					pending_valid_d = pend_after;
					if (ok_since >= reconnect_after_q && !pend_after) begin
						pending_valid_d   = 1'b1;
						pending_is_info_d = 1'b1;
						pending_tag_d     = '0;
						success_valid_d   = 1'b0;
					end
					cooldown_ms_d      = (cd_dbl > {1'b0, cooldown_max_q}) ? cooldown_max_q
					                                                       : cd_dbl[15:0];
					cooldown_valid_d   = 1'b1;
					cooldown_pending_d = 1'b1;
				end
			end
			OP_POST: begin
				pending_valid_d   = 1'b1;
				pending_is_info_d = req.event_is_info;
				pending_tag_d     = req.event_tag;
			end
		endcase
	end

	// scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cooldown_pending_q <= 1'b0;
			cooldown_valid_q   <= 1'b0;
			cooldown_ms_q      <= '0;
			failed_count_q     <= '0;
			telemetry_valid_q  <= 1'b0;
			telemetry_stamp_q  <= '0;
			success_valid_q    <= 1'b0;
			success_stamp_q    <= '0;
			pending_valid_q    <= 1'b0;
			pending_is_info_q  <= 1'b0;
			pending_tag_q      <= '0;
			info_dirty_q       <= 1'b1;
		end else if (accept) begin
			cooldown_pending_q <= cooldown_pending_d;
			cooldown_valid_q   <= cooldown_valid_d;
			cooldown_ms_q      <= cooldown_ms_d;
			failed_count_q     <= failed_count_d;
			telemetry_valid_q  <= telemetry_valid_d;
			telemetry_stamp_q  <= telemetry_stamp_d;
			success_valid_q    <= success_valid_d;
			success_stamp_q    <= success_stamp_d;
			pending_valid_q    <= pending_valid_d;
			pending_is_info_q  <= pending_is_info_d;
			pending_tag_q      <= pending_tag_d;
			info_dirty_q       <= info_dirty_d;
		end
	end

	// output register and skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (accept) begin
			skid_q <= res;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.action       = out_q.action;
	assign rsp.sleep_ms     = out_q.sleep_ms;
	assign rsp.sent_tag     = out_q.sent_tag;
	assign rsp.sent_is_info = out_q.sent_is_info;

endmodule
`default_nettype wire
